### rtl/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types and codes for the acknowledged command dispatcher.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam logic [1:0] ACT_SUBMIT = 2'd0;
  localparam logic [1:0] ACT_ACK    = 2'd1;
  localparam logic [1:0] ACT_POLL   = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  localparam logic [2:0] RES_SEND     = 3'd0;
  localparam logic [2:0] RES_WARN     = 3'd1;
  localparam logic [2:0] RES_ACK_OK   = 3'd2;
  localparam logic [2:0] RES_ACK_REJ  = 3'd3;
  localparam logic [2:0] RES_ACK_UNK  = 3'd4;
  localparam logic [2:0] RES_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  kind;
    logic        mode;
    logic [15:0] value;
    logic [15:0] interval;
    logic [31:0] ack_id;
    logic        accepted;
    logic [31:0] now;
  } cmd_t;

endpackage

### rtl/acd_front.sv
// ----------------------------------------------------------------------------
// acd_front
// Accepts words, drops ignored ones and queues the rest for the engine.
// ----------------------------------------------------------------------------
module acd_front #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  acd_pkg::cmd_t in_cmd,
  output logic          q_valid,
  output acd_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import acd_pkg::*;

  cmd_t        q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        keep, push;

  assign busy = (cnt_r == 2'd2);
  assign keep = (in_cmd.action == ACT_ACK) || (in_cmd.action == ACT_POLL) ||
                ((in_cmd.action == ACT_SUBMIT) && (in_cmd.kind != 4'd0) &&
                 ({28'd0, in_cmd.kind} <= 32'(SLOTS)));
  assign push = start && !busy && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("push into full queue");
endmodule

### rtl/acd_engine.sv
// ----------------------------------------------------------------------------
// acd_engine
// Slot state and a sequencer that walks the slots one per cycle.
// ----------------------------------------------------------------------------
module acd_engine #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          q_valid,
  input  acd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          idle,
  output logic          out_valid,
  output logic [2:0]    result_type,
  output logic [3:0]    out_kind,
  output logic          out_mode,
  output logic [15:0]   out_value,
  output logic [15:0]   out_interval,
  output logic [31:0]   req_id,
  output logic          last
);
  import acd_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACK  = 3'd1;
  localparam logic [2:0] ST_SEND = 3'd2;
  localparam logic [2:0] ST_WARN = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [SW-1:0] s_r;
  cmd_t        c_r;
  logic [15:0] tmo_r;
  logic [31:0] nid_r;

  logic        df_r [SLOTS];
  logic        dm_r [SLOTS];
  logic [15:0] dv_r [SLOTS];
  logic [15:0] di_r [SLOTS];
  logic        es_r [SLOTS];
  logic [15:0] sv_r [SLOTS];
  logic [31:0] lt_r [SLOTS];
  logic [31:0] li_r [SLOTS];
  logic        pa_r [SLOTS];
  logic [31:0] ps_r [SLOTS];
  logic        tw_r [SLOTS];

  logic [31:0] t_diff, p_diff, nid_inc;
  logic        snd, wrn, s_end, hit;
  logic [SW-1:0] hit_s;
  logic        out_valid_nxt;

  assign idle = (st_r == ST_IDLE) && !q_valid && !out_valid;
  assign q_pop = (st_r == ST_IDLE) && q_valid;
  assign s_end = ({{(32-SW){1'b0}}, s_r} == 32'(SLOTS - 1));
  assign t_diff = c_r.now - lt_r[s_r];
  assign p_diff = c_r.now - ps_r[s_r];
  assign nid_inc = (nid_r == 32'hFFFF_FFFF) ? 32'd1 : nid_r + 32'd1;
  assign snd = df_r[s_r] && (dm_r[s_r] ? (!es_r[s_r] || di_r[s_r] == 16'd0 ||
               t_diff >= {16'd0, di_r[s_r]}) : !(es_r[s_r] && sv_r[s_r] == dv_r[s_r]));
  assign wrn = (tmo_r != 16'd0) && pa_r[s_r] && !tw_r[s_r] && (p_diff > {16'd0, tmo_r});
  assign out_valid_nxt = (st_r == ST_ACK) || (st_r == ST_CLR) ||
                         ((st_r == ST_SEND) && snd) || ((st_r == ST_WARN) && wrn);

  always_comb begin
    hit = 1'b0;
    hit_s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (li_r[i] != 32'd0 && li_r[i] == c_r.ack_id) begin
        hit = 1'b1;
        hit_s = SW'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        unique case (q_cmd.action)
          ACT_ACK:  st_nxt = ST_ACK;
          ACT_POLL: st_nxt = ST_SEND;
          default:  st_nxt = ST_IDLE;
        endcase
      end
      ST_ACK:  st_nxt = ST_IDLE;
      ST_SEND: if (s_end) st_nxt = ST_WARN;
      ST_WARN: if (s_end) st_nxt = ST_CLR;
      ST_CLR:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      s_r <= '0;
      tmo_r <= 16'd0;
      nid_r <= 32'd1;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        df_r[i] <= 1'b0; dm_r[i] <= 1'b0; dv_r[i] <= 16'd0; di_r[i] <= 16'd0;
        es_r[i] <= 1'b0; sv_r[i] <= 16'd0; lt_r[i] <= 32'd0; li_r[i] <= 32'd0;
        pa_r[i] <= 1'b0; ps_r[i] <= 32'd0; tw_r[i] <= 1'b0;
      end
    end else begin
      st_r <= st_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_we) tmo_r <= cfg_wdata;
      if (st_r == ST_IDLE && q_valid) begin
        c_r <= q_cmd;
        s_r <= '0;
        if (q_cmd.action == ACT_SUBMIT) begin
          df_r[SW'(q_cmd.kind - 4'd1)] <= 1'b1;
          dm_r[SW'(q_cmd.kind - 4'd1)] <= q_cmd.mode;
          dv_r[SW'(q_cmd.kind - 4'd1)] <= q_cmd.value;
          di_r[SW'(q_cmd.kind - 4'd1)] <= q_cmd.interval;
        end
      end
      unique case (st_r)
        ST_ACK: begin
          result_type <= !hit ? RES_ACK_UNK : (c_r.accepted ? RES_ACK_OK : RES_ACK_REJ);
          out_kind <= hit ? 4'({1'b0, hit_s} + 5'd1) : 4'd0;
          out_mode <= 1'b0; out_value <= 16'd0; out_interval <= 16'd0;
          req_id <= c_r.ack_id;
          last <= 1'b1;
          if (hit) begin
            pa_r[hit_s] <= 1'b0;
            if (pa_r[hit_s]) tw_r[hit_s] <= 1'b0;
          end
        end
        ST_SEND: begin
          s_r <= s_end ? '0 : s_r + SW'(1);
          if (snd) begin
            result_type <= RES_SEND;
            out_kind <= 4'({1'b0, s_r} + 5'd1);
            out_mode <= dm_r[s_r]; out_value <= dv_r[s_r]; out_interval <= di_r[s_r];
            req_id <= nid_r;
            last <= 1'b0;
            nid_r <= nid_inc;
            es_r[s_r] <= 1'b1; sv_r[s_r] <= dv_r[s_r];
            lt_r[s_r] <= c_r.now; li_r[s_r] <= nid_r;
            if (!dm_r[s_r]) begin
              pa_r[s_r] <= 1'b1; ps_r[s_r] <= c_r.now; tw_r[s_r] <= 1'b0;
            end
          end
        end
        ST_WARN: begin
          s_r <= s_end ? '0 : s_r + SW'(1);
          if (wrn) begin
            result_type <= RES_WARN;
            out_kind <= 4'({1'b0, s_r} + 5'd1);
            out_mode <= 1'b0; out_value <= 16'd0; out_interval <= 16'd0;
            req_id <= li_r[s_r];
            last <= 1'b0;
            tw_r[s_r] <= 1'b1;
          end
        end
        ST_CLR: begin
          result_type <= RES_DONE;
          out_kind <= 4'd0; out_mode <= 1'b0; out_value <= 16'd0; out_interval <= 16'd0;
          req_id <= 32'd0;
          last <= 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            df_r[i] <= 1'b0;
            if (!df_r[i]) begin
              dm_r[i] <= 1'b0; dv_r[i] <= 16'd0; di_r[i] <= 16'd0;
              es_r[i] <= 1'b0; sv_r[i] <= 16'd0; lt_r[i] <= 32'd0; li_r[i] <= 32'd0;
              pa_r[i] <= 1'b0; ps_r[i] <= 32'd0; tw_r[i] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_nid_nz: assert property (@(posedge clk) disable iff (!rst_n)
    nid_r != 32'd0) else $error("request id reached zero");
  a_send_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_type == RES_SEND |-> req_id != 32'd0)
    else $error("send with zero id");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(st_r) == ST_CLR |-> out_valid && last) else $error("missing done");
endmodule

### rtl/acked_command_dispatcher_top.sv
// ----------------------------------------------------------------------------
// acked_command_dispatcher_top
// Command dispatcher with per-kind slots, acks and timeout warnings.
// ----------------------------------------------------------------------------
// Usage:
//   a word is taken when start is high and busy is low; a two-entry queue
//   sits between intake and the slot engine, busy rises only when it is full
//   submits for kinds outside 1..SLOTS and unknown actions are dropped at intake
//   results come out at most one per cycle on the out_ ports, marked by
//   out_valid; last marks the final result of a word; the receiver cannot stall
//   cfg_we writes the warning timeout; write it only while the block is idle
//   latency: submit 1 cycle, ack 3 cycles to its result
//   a poll takes 2*SLOTS+3 cycles (two walks of the slot engine, one slot
//   per cycle, plus the done marker), 19 at eight slots
//   the engine is tied up for 1 cycle per submit, 2 per ack and
//   2*SLOTS+2 per poll
//   reset clears all slots, sets the next request id to one and the
//   timeout to zero
// ----------------------------------------------------------------------------
module acked_command_dispatcher_top #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_kind,
  input  logic        in_mode,
  input  logic [15:0] in_value,
  input  logic [15:0] in_interval,
  input  logic [31:0] in_ack_reqid,
  input  logic        in_ack_accepted,
  input  logic [31:0] in_now,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_result_type,
  output logic [3:0]  out_kind,
  output logic        out_mode,
  output logic [15:0] out_value,
  output logic [15:0] out_interval,
  output logic [31:0] out_reqid,
  output logic        out_last
);
  import acd_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop, eng_idle;

  assign in_cmd = '{action: in_action, kind: in_kind, mode: in_mode, value: in_value,
                    interval: in_interval, ack_id: in_ack_reqid,
                    accepted: in_ack_accepted, now: in_now};

  acd_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .q_valid, .q_cmd, .q_pop
  );

  acd_engine #(.SLOTS(SLOTS)) u_engine (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_cmd, .q_pop,
    .idle(eng_idle), .out_valid,
    .result_type(out_result_type), .out_kind, .out_mode, .out_value,
    .out_interval, .req_id(out_reqid), .last(out_last)
  );

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    eng_idle |=> !out_valid) else $error("result from idle engine");
  a_not_busy_rst: assert property (@(posedge clk)
    !rst_n |=> !busy) else $error("busy after reset");
  a_busy_q: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_valid) else $error("busy with empty queue");
endmodule
